// File: rtl/must_cache_age_update_assert.svh
// Assertion macros shared by the cache age update RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef MUST_CACHE_AGE_UPDATE_ASSERT_SVH
`define MUST_CACHE_AGE_UPDATE_ASSERT_SVH

// Checked on every rising edge while out of reset.
`define MCAU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MCAU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/mcau_pkg.sv
package mcau_pkg;

	// Field widths of the transfers.
	localparam int AGE_W = 4;
	localparam int ACT_W = 3;
	localparam int BID_W = 6;
	localparam int ASSOC_W = 4;

	// Default sizes of the tracked set.
	localparam int BLOCKS_DEF = 64;
	localparam int MAX_WAYS_DEF = 8;

	// Associativity after reset and the largest age that fits in an age field.
	localparam logic [ASSOC_W-1:0] ASSOC_RESET = 4'd8;
	localparam int AGE_CAP = 15;

	// Access kinds.
	typedef enum logic [ACT_W-1:0] {
		ACT_NONE           = 3'd0,
		ACT_ACCESS_BLOCK   = 3'd1,
		ACT_ACCESS_UNKNOWN = 3'd2,
		ACT_PURGE_BLOCK    = 3'd3,
		ACT_PURGE_UNKNOWN  = 3'd4,
		ACT_SET_TOP        = 3'd5,
		ACT_SET_BOTTOM     = 3'd6
	} action_t;

	// One step handed to the age file.
	typedef struct packed {
		logic              fire;
		logic [ACT_W-1:0]  action;
		logic [BID_W-1:0]  block_id;
		logic              hits_set;
	} step_t;

	// Result of one step.
	typedef struct packed {
		logic [AGE_W-1:0] block_age;
		logic             is_top;
		logic             is_bottom;
	} result_t;

	// Associativity clamped to 1 .. min(max_ways, AGE_CAP).
	function automatic logic [AGE_W-1:0] eff_assoc(input logic [ASSOC_W-1:0] assoc,
			input int max_ways);
		int hi;
		logic [AGE_W-1:0] hi_v;
		hi = (max_ways < AGE_CAP) ? max_ways : AGE_CAP;
		hi_v = AGE_W'(hi);
		if (assoc == '0) begin
			return AGE_W'(1);
		end else if (AGE_W'(assoc) > hi_v) begin
			return hi_v;
		end
		return AGE_W'(assoc);
	endfunction

endpackage

// File: rtl/must_cache_age_update.sv
// Channel   Direction  tdata bits (lowest first)
// s_axis    in         action[2:0], block_id[8:3], hits_set[9], zero[15:10]
// m_axis    out        block_age[3:0], is_top[4], is_bottom[5], zero[7:6]
// cfg       in         cfg_wdata = assoc, written when cfg_we is high
//
// One access per clock is sustained while the output is not stalled; each result passes the input and output registers.
// The input register feeds a single pass over all age lanes into the output register.
// Reset sets every age to the reset associativity (top) and clears the bottom flag.
// A stalled output holds its result while one more access waits in the input register.
`include "must_cache_age_update_assert.svh"

module must_cache_age_update #(
	parameter int BLOCKS   = mcau_pkg::BLOCKS_DEF,
	parameter int MAX_WAYS = mcau_pkg::MAX_WAYS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// action[2:0], block_id[8:3], hits_set[9], zero fill above
	input  logic [15:0]                    s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// block_age[3:0], is_top[4], is_bottom[5], zero fill above
	output logic [7:0]                     m_axis_tdata,
	input  logic                           cfg_we,
	input  logic [mcau_pkg::ASSOC_W-1:0]   cfg_wdata
);

	logic                           in_valid_s1;
	logic [mcau_pkg::ACT_W-1:0]     action_s1;
	logic [mcau_pkg::BID_W-1:0]     block_id_s1;
	logic                           hits_set_s1;
	logic                           out_valid_q;
	mcau_pkg::result_t              out_res_q;
	logic [mcau_pkg::ASSOC_W-1:0]   assoc_q;

	logic                           s_fire;
	logic                           advance;
	logic [mcau_pkg::AGE_W-1:0]     eff_a;
	mcau_pkg::step_t                step;
	mcau_pkg::result_t              result;

	// Handshake: a step runs when the output register is free or being drained.
	assign advance = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign eff_a = mcau_pkg::eff_assoc(assoc_q, MAX_WAYS);

	assign step.fire = advance;
	assign step.action = action_s1;
	assign step.block_id = block_id_s1;
	assign step.hits_set = hits_set_s1;

	mcau_age_file #(
		.BLOCKS (BLOCKS)
	) u_age_file (
		.clk    (clk),
		.arst_n (arst_n),
		.eff_a  (eff_a),
		.step   (step),
		.result (result)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assoc_q <= mcau_pkg::ASSOC_RESET;
		end else if (cfg_we) begin
			assoc_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_fire) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			action_s1 <= s_axis_tdata[2:0];
			block_id_s1 <= s_axis_tdata[8:3];
			hits_set_s1 <= s_axis_tdata[9];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_res_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {2'b00, out_res_q.is_bottom, out_res_q.is_top, out_res_q.block_age};

	// Top and bottom exclude each other in every delivered result.
	`MCAU_ASSERT(a_top_bottom_excl, out_valid_q |-> !(out_res_q.is_top && out_res_q.is_bottom), "top and bottom both set")
	// A bottom result always reports age zero.
	`MCAU_ASSERT(a_bottom_age_zero, (out_valid_q && out_res_q.is_bottom) |-> (out_res_q.block_age == '0), "bottom result with nonzero age")
	// Setting top yields a top result in the next cycle.
	`MCAU_ASSERT(a_set_top_result, (advance && action_s1 == mcau_pkg::ACT_SET_TOP) |=> (out_valid_q && out_res_q.is_top), "set top did not give top")
	// A waiting access that cannot run stays in the input register.
	`MCAU_ASSERT(a_stall_holds, (in_valid_s1 && !advance) |=> in_valid_s1, "waiting access lost")
	// No result is shown while in reset.
	`MCAU_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid_q, "output valid during reset")

endmodule

// File: rtl/mcau_age_file.sv
module mcau_age_file #(
	parameter int BLOCKS = mcau_pkg::BLOCKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [mcau_pkg::AGE_W-1:0]     eff_a,
	input  mcau_pkg::step_t                step,
	output mcau_pkg::result_t              result
);

	localparam int AW = mcau_pkg::AGE_W;
	localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
	localparam int CMP_W = ((IDX_W > mcau_pkg::BID_W) ? IDX_W : mcau_pkg::BID_W) + 1;

	logic [AW-1:0]    age_q [BLOCKS];
	logic             bottom_q;

	logic [AW-1:0]    sat [BLOCKS];
	logic [AW-1:0]    age_d [BLOCKS];
	logic [BLOCKS-1:0] sel;
	logic [CMP_W-1:0] bid_ext;
	logic             valid_id;
	logic             live;
	logic             bottom_d;
	logic             all_top;
	logic [AW-1:0]    ba;
	logic [AW-1:0]    new_ba;
	mcau_pkg::action_t act;

	// Next ages of every lane in parallel, plus the result of the step.
	always_comb begin
		act = mcau_pkg::action_t'(step.action);
		bid_ext = CMP_W'(step.block_id);
		valid_id = bid_ext < CMP_W'(BLOCKS);
		live = step.hits_set && !bottom_q;

		// Clamp stored ages to the current associativity and pick the named block.
		ba = '0;
		for (int i = 0; i < BLOCKS; i++) begin
			sat[i] = (age_q[i] > eff_a) ? eff_a : age_q[i];
			sel[i] = valid_id && (bid_ext == CMP_W'(i));
			ba = ba | (sat[i] & {AW{sel[i]}});
		end

		bottom_d = bottom_q;
		if (act == mcau_pkg::ACT_SET_TOP) begin
			bottom_d = 1'b0;
		end else if (act == mcau_pkg::ACT_SET_BOTTOM) begin
			bottom_d = 1'b1;
		end

		new_ba = '0;
		all_top = 1'b1;
		for (int i = 0; i < BLOCKS; i++) begin
			unique case (act)
				mcau_pkg::ACT_SET_TOP: begin
					age_d[i] = eff_a;
				end
				mcau_pkg::ACT_ACCESS_BLOCK: begin
					if (live && valid_id) begin
						if (sel[i]) begin
							age_d[i] = '0;
						end else if (sat[i] <= ba && sat[i] < eff_a) begin
							age_d[i] = sat[i] + AW'(1);
						end else begin
							age_d[i] = sat[i];
						end
					end else begin
						age_d[i] = sat[i];
					end
				end
				mcau_pkg::ACT_ACCESS_UNKNOWN: begin
					age_d[i] = (live && sat[i] < eff_a) ? sat[i] + AW'(1) : sat[i];
				end
				mcau_pkg::ACT_PURGE_BLOCK: begin
					age_d[i] = (live && sel[i]) ? eff_a : sat[i];
				end
				mcau_pkg::ACT_PURGE_UNKNOWN: begin
					age_d[i] = live ? eff_a : sat[i];
				end
				default: begin
					age_d[i] = sat[i];
				end
			endcase
			new_ba = new_ba | (age_d[i] & {AW{sel[i]}});
			all_top = all_top && (age_d[i] == eff_a);
		end

		result.is_bottom = bottom_d;
		result.is_top = !bottom_d && all_top;
		if (bottom_d) begin
			result.block_age = '0;
		end else if (valid_id) begin
			result.block_age = new_ba;
		end else begin
			result.block_age = eff_a;
		end
	end

	// Age lanes and bottom flag, written once per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bottom_q <= 1'b0;
			for (int i = 0; i < BLOCKS; i++) begin
				age_q[i] <= AW'(mcau_pkg::ASSOC_RESET);
			end
		end else if (step.fire) begin
			bottom_q <= bottom_d;
			for (int i = 0; i < BLOCKS; i++) begin
				age_q[i] <= age_d[i];
			end
		end
	end

endmodule

// File: tb/testbench.sv
module testbench;

	localparam int NUM_BLOCKS = mcau_pkg::BLOCKS_DEF;
	localparam int WAYS = mcau_pkg::MAX_WAYS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 4;
	// Action code that the package leaves unnamed.
	localparam logic [mcau_pkg::ACT_W-1:0] ACT_UNUSED = 3'd7;

	typedef struct {
		logic [mcau_pkg::ACT_W-1:0] action;
		logic [mcau_pkg::BID_W-1:0] block_id;
		logic                       hits_set;
	} access_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic cfg_we;
	logic [mcau_pkg::ASSOC_W-1:0] cfg_wdata;

	// Shadow copy of the age file, the bottom flag and the associativity register.
	logic [mcau_pkg::AGE_W-1:0] age_shadow [NUM_BLOCKS];
	logic bottom_shadow;
	logic [mcau_pkg::ASSOC_W-1:0] assoc_shadow;

	mcau_pkg::result_t pending_ages [$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	bit rx_hold_req = 1'b0;

	must_cache_age_update u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	// Clock and the single reset pulse at the start of the run.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Associativity clamped to 1 .. WAYS.
	function automatic logic [mcau_pkg::AGE_W-1:0] clamped_ways(
			input logic [mcau_pkg::ASSOC_W-1:0] raw);
		if (raw == '0) begin
			return mcau_pkg::AGE_W'(1);
		end else if (int'(raw) > WAYS) begin
			return mcau_pkg::AGE_W'(WAYS);
		end
		return mcau_pkg::AGE_W'(raw);
	endfunction

	// Applies one access to the shadow ages and returns the result it should produce.
	function automatic mcau_pkg::result_t apply_access(input access_t acc);
		logic [mcau_pkg::AGE_W-1:0] ways;
		logic [mcau_pkg::AGE_W-1:0] named_age;
		logic all_top;
		mcau_pkg::result_t res;
		ways = clamped_ways(assoc_shadow);
		// Ages left above a lowered associativity are saturated first.
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			if (age_shadow[i] > ways) age_shadow[i] = ways;
		end
		if (acc.action == mcau_pkg::ACT_SET_TOP) begin
			bottom_shadow = 1'b0;
			for (int i = 0; i < NUM_BLOCKS; i++) age_shadow[i] = ways;
		end else if (acc.action == mcau_pkg::ACT_SET_BOTTOM) begin
			bottom_shadow = 1'b1;
		end else if (acc.hits_set && !bottom_shadow) begin
			if (acc.action == mcau_pkg::ACT_ACCESS_BLOCK) begin
				named_age = age_shadow[acc.block_id];
				for (int i = 0; i < NUM_BLOCKS; i++) begin
					if (age_shadow[i] <= named_age && age_shadow[i] < ways)
						age_shadow[i] = age_shadow[i] + 1'b1;
				end
				age_shadow[acc.block_id] = '0;
			end else if (acc.action == mcau_pkg::ACT_ACCESS_UNKNOWN) begin
				for (int i = 0; i < NUM_BLOCKS; i++) begin
					if (age_shadow[i] < ways) age_shadow[i] = age_shadow[i] + 1'b1;
				end
			end else if (acc.action == mcau_pkg::ACT_PURGE_BLOCK) begin
				age_shadow[acc.block_id] = ways;
			end else if (acc.action == mcau_pkg::ACT_PURGE_UNKNOWN) begin
				for (int i = 0; i < NUM_BLOCKS; i++) age_shadow[i] = ways;
			end
		end
		all_top = !bottom_shadow;
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			if (age_shadow[i] != ways) all_top = 1'b0;
		end
		res.block_age = bottom_shadow ? '0 : age_shadow[acc.block_id];
		res.is_top = all_top;
		res.is_bottom = bottom_shadow;
		return res;
	endfunction

	function automatic access_t make_access(input logic [mcau_pkg::ACT_W-1:0] action,
			input int block_id, input bit hits_set);
		access_t acc;
		acc.action = action;
		acc.block_id = mcau_pkg::BID_W'(block_id);
		acc.hits_set = hits_set;
		return acc;
	endfunction

	// Offers one access until the transfer happens, then records its expected result.
	task automatic send_access(input access_t acc);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, acc.hits_set, acc.block_id, acc.action};
		do @(posedge clk); while (!s_axis_tready);
		pending_ages.push_back(apply_access(acc));
		gap = (tx_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Waits until every result is back and the pipeline has emptied.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_ages.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_assoc(input logic [mcau_pkg::ASSOC_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		assoc_shadow = value;
		cfg_we <= 1'b0;
	endtask

	// Mostly named accesses within a working set, so that ages climb and order up.
	function automatic access_t random_access(input int work_set);
		int pick;
		int id;
		access_t acc;
		pick = $urandom_range(0, 199);
		id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_BLOCKS - 1)
			: $urandom_range(0, work_set - 1);
		acc = make_access(mcau_pkg::ACT_ACCESS_BLOCK, id, $urandom_range(0, 9) != 0);
		if (pick >= 200 - 4) acc.action = ACT_UNUSED;
		else if (pick >= 200 - 10) acc.action = mcau_pkg::ACT_NONE;
		else if (pick >= 200 - 12) acc.action = mcau_pkg::ACT_SET_BOTTOM;
		else if (pick >= 200 - 18) acc.action = mcau_pkg::ACT_SET_TOP;
		else if (pick >= 200 - 23) acc.action = mcau_pkg::ACT_PURGE_UNKNOWN;
		else if (pick >= 200 - 43) acc.action = mcau_pkg::ACT_PURGE_BLOCK;
		else if (pick >= 200 - 73) acc.action = mcau_pkg::ACT_ACCESS_UNKNOWN;
		return acc;
	endfunction

	// Every action, inside and outside the set, in and out of the bottom state.
	task automatic test_directed();
		send_access(make_access(mcau_pkg::ACT_ACCESS_BLOCK, 0, 1'b1));
		send_access(make_access(mcau_pkg::ACT_ACCESS_BLOCK, 63, 1'b1));
		send_access(make_access(mcau_pkg::ACT_ACCESS_BLOCK, 5, 1'b1));
		send_access(make_access(mcau_pkg::ACT_ACCESS_BLOCK, 0, 1'b1));
		send_access(make_access(mcau_pkg::ACT_ACCESS_UNKNOWN, 5, 1'b1));
		send_access(make_access(mcau_pkg::ACT_PURGE_BLOCK, 63, 1'b1));
		send_access(make_access(mcau_pkg::ACT_ACCESS_BLOCK, 7, 1'b0));
		send_access(make_access(mcau_pkg::ACT_ACCESS_UNKNOWN, 0, 1'b0));
		send_access(make_access(mcau_pkg::ACT_PURGE_BLOCK, 0, 1'b0));
		send_access(make_access(mcau_pkg::ACT_PURGE_UNKNOWN, 5, 1'b0));
		send_access(make_access(mcau_pkg::ACT_PURGE_UNKNOWN, 5, 1'b1));
		send_access(make_access(mcau_pkg::ACT_ACCESS_BLOCK, 42, 1'b1));
		send_access(make_access(mcau_pkg::ACT_SET_BOTTOM, 42, 1'b0));
		send_access(make_access(mcau_pkg::ACT_ACCESS_BLOCK, 1, 1'b1));
		send_access(make_access(mcau_pkg::ACT_ACCESS_UNKNOWN, 1, 1'b1));
		send_access(make_access(mcau_pkg::ACT_PURGE_BLOCK, 42, 1'b1));
		send_access(make_access(mcau_pkg::ACT_PURGE_UNKNOWN, 42, 1'b1));
		send_access(make_access(mcau_pkg::ACT_NONE, 63, 1'b1));
		send_access(make_access(ACT_UNUSED, 42, 1'b1));
		send_access(make_access(mcau_pkg::ACT_SET_TOP, 42, 1'b0));
		send_access(make_access(mcau_pkg::ACT_SET_BOTTOM, 21, 1'b1));
		send_access(make_access(mcau_pkg::ACT_SET_TOP, 21, 1'b1));
		send_access(make_access(ACT_UNUSED, 63, 1'b0));
		send_access(make_access(mcau_pkg::ACT_NONE, 0, 1'b0));
	endtask

	// Associativity at and beyond its limits, and shrinking with ages still stored.
	task automatic test_assoc_limits();
		logic [mcau_pkg::ASSOC_W-1:0] settings [5] = '{4'd1, 4'd0, 4'd15, 4'd9, 4'd8};
		foreach (settings[k]) begin
			write_assoc(settings[k]);
			send_access(make_access(mcau_pkg::ACT_ACCESS_BLOCK, 3, 1'b1));
			send_access(make_access(mcau_pkg::ACT_ACCESS_BLOCK, 60, 1'b1));
			send_access(make_access(mcau_pkg::ACT_ACCESS_UNKNOWN, 3, 1'b1));
			send_access(make_access(mcau_pkg::ACT_ACCESS_BLOCK, 60, 1'b1));
		end
		// Spread ages up to seven, then lower the limit so stored ages saturate.
		for (int i = 0; i < 8; i++) begin
			send_access(make_access(mcau_pkg::ACT_ACCESS_BLOCK, i, 1'b1));
		end
		write_assoc(4'd2);
		send_access(make_access(mcau_pkg::ACT_NONE, 0, 1'b1));
		write_assoc(4'd8);
		send_access(make_access(mcau_pkg::ACT_NONE, 1, 1'b1));
		send_access(make_access(mcau_pkg::ACT_ACCESS_BLOCK, 1, 1'b1));
	endtask

	// Random phases over several associativities, one with a long output stall.
	task automatic test_random();
		logic [mcau_pkg::ASSOC_W-1:0] settings [9] =
			'{4'd8, 4'd1, 4'd4, 4'd15, 4'd0, 4'd2, 4'd7, 4'd3, 4'd8};
		int work_set;
		foreach (settings[k]) begin
			write_assoc(settings[k]);
			tx_idle = (k % 3) != 2;
			rx_idle = (k % 4) != 3;
			work_set = (k == 6) ? NUM_BLOCKS : $urandom_range(4, 20);
			send_access(make_access(mcau_pkg::ACT_SET_TOP, 0, 1'b1));
			if (k == 2) begin
				// The receiver holds off while items keep coming, so the input stalls.
				tx_idle = 1'b0;
				rx_hold_req = 1'b1;
				repeat (40) send_access(random_access(work_set));
				tx_idle = 1'b1;
			end
			repeat (140) send_access(random_access(work_set));
		end
	endtask

	// Back-to-back traffic with no idling on either side.
	task automatic test_full_rate();
		write_assoc(4'd6);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		repeat (90) send_access(random_access(10));
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else if (rx_idle && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		mcau_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_ages.size() == 0) begin
				$error("result transfer with no expectation, tdata %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = pending_ages.pop_front();
				if (m_axis_tdata[3:0] !== want.block_age) begin
					$error("block_age: expected %0d, got %0d", want.block_age, m_axis_tdata[3:0]);
					mismatches++;
				end
				if (m_axis_tdata[4] !== want.is_top) begin
					$error("is_top: expected %0d, got %0d", want.is_top, m_axis_tdata[4]);
					mismatches++;
				end
				if (m_axis_tdata[5] !== want.is_bottom) begin
					$error("is_bottom: expected %0d, got %0d", want.is_bottom, m_axis_tdata[5]);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		assoc_shadow = mcau_pkg::ASSOC_RESET;
		bottom_shadow = 1'b0;
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			age_shadow[i] = clamped_ways(mcau_pkg::ASSOC_RESET);
		end
		@(posedge arst_n);
		@(posedge clk);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		test_directed();
		test_assoc_limits();
		test_random();
		test_full_rate();
		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/mcau_pkg.sv
rtl/mcau_age_file.sv
rtl/must_cache_age_update.sv
tb/testbench.sv
